>>> rtl/tpfb_pkg.sv
// ----------------------------------------------------------------------------
// tpfb_pkg
// Shared widths, latencies and payload types of the three point frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package tpfb_pkg;

    localparam int COORD_BITS = 24;
    localparam int ROT_BITS   = 32;
    localparam int RED_BITS   = 30;
    localparam int RED_W      = RED_BITS + 1;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * RED_W;
    localparam int SQ_W       = 2 * RED_BITS;
    localparam int N2_W       = SQ_W + 2;
    localparam int RED_LAT    = 3;
    localparam int CROSS_LAT  = 2;

    typedef logic signed [COORD_BITS-1:0] t_coord;
    typedef logic signed [ROT_BITS-1:0]   t_rot;
    typedef logic signed [RED_W-1:0]      t_red;
    typedef logic signed [PROD_W-1:0]     t_prod;

    typedef struct packed {
        t_coord origin_x;
        t_coord origin_y;
        t_coord origin_z;
        t_coord axis_pt_x;
        t_coord axis_pt_y;
        t_coord axis_pt_z;
        t_coord plane_pt_x;
        t_coord plane_pt_y;
        t_coord plane_pt_z;
    } t_in_item;

    typedef struct packed {
        t_rot   rot_00;
        t_rot   rot_01;
        t_rot   rot_02;
        t_rot   rot_10;
        t_rot   rot_11;
        t_rot   rot_12;
        t_rot   rot_20;
        t_rot   rot_21;
        t_rot   rot_22;
        t_coord shift_x;
        t_coord shift_y;
        t_coord shift_z;
    } t_out_item;

endpackage

`default_nettype wire

>>> rtl/three_point_frame_builder.sv
// ----------------------------------------------------------------------------
// three_point_frame_builder
// Builds a rotation matrix and translation from origin, axis and plane points.
// ----------------------------------------------------------------------------
// A new point triple is taken every cycle while the skid is empty; the frame
// pipeline is mostly the per-element restoring divider (2*ROT_FRAC_BITS+3
// stages) and square root (ROT_FRAC_BITS+2 stages) behind the two cross
// products. The whole pipeline advances on one enable; an output register and
// a one-entry skid keep accepting requests after the consumer stalls, until a
// finished frame has to wait in the skid.
`default_nettype none

module three_point_frame_builder #(
    parameter int ROT_FRAC_BITS = 30
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  tpfb_pkg::t_in_item  i_in_data,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output tpfb_pkg::t_out_item o_out_data,
    input  logic                i_out_ready
);
    import tpfb_pkg::*;

    localparam int F        = ROT_FRAC_BITS;
    localparam int COL_LAT  = 3 * F + 8;
    localparam int XD       = CROSS_LAT + RED_LAT;
    localparam int PIPE_LAT = 1 + 3 * RED_LAT + 2 * CROSS_LAT + COL_LAT;
    localparam int OW       = 3 * COORD_BITS;

    logic                     w_en;
    logic signed [DIFF_W-1:0] r_x [3];
    logic signed [DIFF_W-1:0] r_p [3];
    logic                     r_v1;
    logic                     w_vxr;
    t_red                     w_xr [3];
    t_red                     w_pr [3];
    logic                     w_vz;
    t_prod                    w_z [3];
    logic                     w_vzr;
    t_red                     w_zr [3];
    logic                     w_vy;
    t_prod                    w_y [3];
    logic                     w_vyr;
    t_red                     w_yr [3];
    t_red                     r_xd [2*XD][3];
    t_red                     r_zd [XD][3];
    logic [OW-1:0]            r_od [PIPE_LAT];
    logic                     w_pv;
    t_rot                     w_cx [3];
    t_rot                     w_cy [3];
    t_rot                     w_cz [3];
    t_out_item                w_pipe;
    t_out_item                r_out;
    logic                     r_out_valid;
    t_out_item                r_skid;
    logic                     r_skid_valid;

    assign w_en       = !r_skid_valid;
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_x[0] <= DIFF_W'(i_in_data.axis_pt_x) - DIFF_W'(i_in_data.origin_x);
            r_x[1] <= DIFF_W'(i_in_data.axis_pt_y) - DIFF_W'(i_in_data.origin_y);
            r_x[2] <= DIFF_W'(i_in_data.axis_pt_z) - DIFF_W'(i_in_data.origin_z);
            r_p[0] <= DIFF_W'(i_in_data.plane_pt_x) - DIFF_W'(i_in_data.origin_x);
            r_p[1] <= DIFF_W'(i_in_data.plane_pt_y) - DIFF_W'(i_in_data.origin_y);
            r_p[2] <= DIFF_W'(i_in_data.plane_pt_z) - DIFF_W'(i_in_data.origin_z);
            r_od[0] <= {i_in_data.origin_x, i_in_data.origin_y, i_in_data.origin_z};
            for (int s = 1; s < PIPE_LAT; s++) begin
                r_od[s] <= r_od[s-1];
            end
            r_xd[0] <= w_xr;
            for (int s = 1; s < 2 * XD; s++) begin
                r_xd[s] <= r_xd[s-1];
            end
            r_zd[0] <= w_zr;
            for (int s = 1; s < XD; s++) begin
                r_zd[s] <= r_zd[s-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_in_valid;
        end
    end

    tpfb_reduce #(.W(DIFF_W)) u_red_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_valid (r_v1),
        .i_vec (r_x), .o_valid (w_vxr), .o_vec (w_xr)
    );

    tpfb_reduce #(.W(DIFF_W)) u_red_p (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_valid (r_v1),
        .i_vec (r_p), .o_valid (), .o_vec (w_pr)
    );

    tpfb_cross u_cross_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_valid (w_vxr),
        .i_a (w_xr), .i_b (w_pr), .o_valid (w_vz), .o_vec (w_z)
    );

    tpfb_reduce #(.W(PROD_W)) u_red_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_valid (w_vz),
        .i_vec (w_z), .o_valid (w_vzr), .o_vec (w_zr)
    );

    tpfb_cross u_cross_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_valid (w_vzr),
        .i_a (w_zr), .i_b (r_xd[XD-1]), .o_valid (w_vy), .o_vec (w_y)
    );

    tpfb_reduce #(.W(PROD_W)) u_red_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_valid (w_vy),
        .i_vec (w_y), .o_valid (w_vyr), .o_vec (w_yr)
    );

    tpfb_column #(.F(F)) u_col_x (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_valid (w_vyr),
        .i_vec (r_xd[2*XD-1]), .o_valid (w_pv), .o_rot (w_cx)
    );

    tpfb_column #(.F(F)) u_col_y (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_valid (w_vyr),
        .i_vec (w_yr), .o_valid (), .o_rot (w_cy)
    );

    tpfb_column #(.F(F)) u_col_z (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (w_en), .i_valid (w_vyr),
        .i_vec (r_zd[XD-1]), .o_valid (), .o_rot (w_cz)
    );

    always_comb begin
        w_pipe.rot_00  = w_cx[0];
        w_pipe.rot_10  = w_cx[1];
        w_pipe.rot_20  = w_cx[2];
        w_pipe.rot_01  = w_cy[0];
        w_pipe.rot_11  = w_cy[1];
        w_pipe.rot_21  = w_cy[2];
        w_pipe.rot_02  = w_cz[0];
        w_pipe.rot_12  = w_cz[1];
        w_pipe.rot_22  = w_cz[2];
        w_pipe.shift_x = r_od[PIPE_LAT-1][OW-1 -: COORD_BITS];
        w_pipe.shift_y = r_od[PIPE_LAT-1][2*COORD_BITS-1 -: COORD_BITS];
        w_pipe.shift_z = r_od[PIPE_LAT-1][COORD_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || i_out_ready) begin
            r_out_valid  <= r_skid_valid || (w_en && w_pv);
            r_skid_valid <= 1'b0;
        end else if (w_en && w_pv) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || i_out_ready) begin
            r_out <= r_skid_valid ? r_skid : w_pipe;
        end else if (w_en && w_pv) begin
            r_skid <= w_pipe;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a request while output is empty");

    a_skid_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && !i_out_ready))
        else $error("skid filled without an output stall");

    a_skid_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && i_out_ready) |=> (r_out_valid && !r_skid_valid))
        else $error("skid did not drain into output");

endmodule

`default_nettype wire

>>> rtl/tpfb_reduce.sv
// ----------------------------------------------------------------------------
// tpfb_reduce
// Three stage common right shift of a vector so that all magnitudes lie
// below 2^30, sign kept, truncation toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module tpfb_reduce #(
    parameter int W = 25
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  logic                    i_valid,
    input  logic signed [W-1:0]     i_vec [3],
    output logic                    o_valid,
    output tpfb_pkg::t_red          o_vec [3]
);
    import tpfb_pkg::*;

    localparam int SW = $clog2(W + 1);

    logic [W-1:0]  n_mag [3];
    logic [W-1:0]  r_mag1 [3];
    logic [2:0]    r_sgn1;
    logic [W-1:0]  r_any;
    logic [W-1:0]  r_mag2 [3];
    logic [2:0]    r_sgn2;
    logic [SW-1:0] n_len;
    logic [SW-1:0] n_sh;
    logic [SW-1:0] r_sh;
    logic [2:0]    r_v;
    t_red          n_out [3];
    t_red          r_out [3];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_mag[k] = i_vec[k][W-1] ? W'(-i_vec[k]) : W'(i_vec[k]);
        end
    end

    always_comb begin
        n_len = '0;
        for (int b = 0; b < W; b++) begin
            if (r_any[b]) begin
                n_len = SW'(b + 1);
            end
        end
        if (int'(n_len) > RED_BITS) begin
            n_sh = SW'(int'(n_len) - RED_BITS);
        end else begin
            n_sh = '0;
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_out[k] = RED_W'(r_mag2[k] >> r_sh);
            if (r_sgn2[k]) begin
                n_out[k] = -n_out[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_mag1[k] <= n_mag[k];
                r_sgn1[k] <= i_vec[k][W-1];
                r_mag2[k] <= r_mag1[k];
                r_out[k]  <= n_out[k];
            end
            r_any  <= n_mag[0] | n_mag[1] | n_mag[2];
            r_sgn2 <= r_sgn1;
            r_sh   <= n_sh;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[1:0], i_valid};
        end
    end

    assign o_valid = r_v[2];
    assign o_vec   = r_out;

endmodule

`default_nettype wire

>>> rtl/tpfb_cross.sv
// ----------------------------------------------------------------------------
// tpfb_cross
// Two stage cross product: registered products, then differences.
// ----------------------------------------------------------------------------
`default_nettype none

module tpfb_cross (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  tpfb_pkg::t_red  i_a [3],
    input  tpfb_pkg::t_red  i_b [3],
    output logic            o_valid,
    output tpfb_pkg::t_prod o_vec [3]
);
    import tpfb_pkg::*;

    t_prod      n_p [6];
    t_prod      r_p [6];
    t_prod      r_out [3];
    logic [1:0] r_v;

    assign n_p[0] = i_a[1] * i_b[2];
    assign n_p[1] = i_a[2] * i_b[1];
    assign n_p[2] = i_a[2] * i_b[0];
    assign n_p[3] = i_a[0] * i_b[2];
    assign n_p[4] = i_a[0] * i_b[1];
    assign n_p[5] = i_a[1] * i_b[0];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p      <= n_p;
            r_out[0] <= r_p[0] - r_p[1];
            r_out[1] <= r_p[2] - r_p[3];
            r_out[2] <= r_p[4] - r_p[5];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[0], i_valid};
        end
    end

    assign o_valid = r_v[1];
    assign o_vec   = r_out;

endmodule

`default_nettype wire

>>> rtl/tpfb_elem.sv
// ----------------------------------------------------------------------------
// tpfb_elem
// One rotation element: restoring division floor(v^2 * 2^(2F+2) / n2), one
// quotient bit per stage, then a digit-by-digit square root, one root bit
// per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tpfb_elem #(
    parameter int F = 30
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [tpfb_pkg::SQ_W-1:0] i_v2,
    input  logic [tpfb_pkg::N2_W-1:0] i_n2,
    output logic [F+1:0]              o_root
);
    import tpfb_pkg::*;

    localparam int QB  = 2 * F + 3;
    localparam int SR  = (QB + 1) / 2;
    localparam int RMW = N2_W + 1;
    localparam int DW  = 2 * SR;
    localparam int SRW = SR + 2;
    localparam int CW  = SR + 4;

    logic [N2_W-1:0] r_rem  [QB];
    logic [N2_W-1:0] r_den  [QB];
    logic [QB-1:0]   r_quo  [QB];
    logic [SRW-1:0]  r_srem [SR];
    logic [SR-1:0]   r_root [SR];
    logic [DW-1:0]   r_d    [SR];

    for (genvar gi = 0; gi < QB; gi++) begin : g_div
        logic [N2_W-1:0] prem;
        logic [N2_W-1:0] pden;
        logic [QB-1:0]   pquo;
        logic            nb;
        logic [RMW-1:0]  t;
        logic            ge;
        if (gi == 0) begin : g_first
            assign prem = N2_W'(i_v2 >> 1);
            assign pden = i_n2;
            assign pquo = '0;
            assign nb   = i_v2[0];
        end else begin : g_next
            assign prem = r_rem[gi-1];
            assign pden = r_den[gi-1];
            assign pquo = r_quo[gi-1];
            assign nb   = 1'b0;
        end
        assign t  = {prem, nb};
        assign ge = t >= {1'b0, pden};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gi] <= ge ? N2_W'(t - {1'b0, pden}) : N2_W'(t);
                r_den[gi] <= pden;
                r_quo[gi] <= {pquo[QB-2:0], ge};
            end
        end
    end

    for (genvar gj = 0; gj < SR; gj++) begin : g_sqrt
        logic [SRW-1:0] prem;
        logic [SR-1:0]  proot;
        logic [DW-1:0]  pd;
        logic [CW-1:0]  cur;
        logic [CW-1:0]  trial;
        logic           ge;
        if (gj == 0) begin : g_first
            assign prem  = '0;
            assign proot = '0;
            assign pd    = DW'(r_quo[QB-1]);
        end else begin : g_next
            assign prem  = r_srem[gj-1];
            assign proot = r_root[gj-1];
            assign pd    = r_d[gj-1];
        end
        assign cur   = {prem, pd[DW-1-2*gj -: 2]};
        assign trial = CW'({proot, 2'b01});
        assign ge    = cur >= trial;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_srem[gj] <= ge ? SRW'(cur - trial) : SRW'(cur);
                r_root[gj] <= {proot[SR-2:0], ge};
                r_d[gj]    <= pd;
            end
        end
    end

    assign o_root = r_root[SR-1];

endmodule

`default_nettype wire

>>> rtl/tpfb_column.sv
// ----------------------------------------------------------------------------
// tpfb_column
// Unit vector of one column: squares, squared length, three element lanes,
// then rounding, sign and the zero-length repair.
// ----------------------------------------------------------------------------
`default_nettype none

module tpfb_column #(
    parameter int F = 30
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  tpfb_pkg::t_red i_vec [3],
    output logic           o_valid,
    output tpfb_pkg::t_rot o_rot [3]
);
    import tpfb_pkg::*;

    localparam int QB   = 2 * F + 3;
    localparam int SR   = (QB + 1) / 2;
    localparam int ELAT = QB + SR;
    localparam int LIM  = 1 << F;

    logic [RED_BITS-1:0] n_mag [3];
    logic [SQ_W-1:0]     n_sq  [3];
    logic [SQ_W-1:0]     r_sq  [3];
    logic [2:0]          r_sgna;
    logic                r_va;
    logic [SQ_W-1:0]     r_v2  [3];
    logic [N2_W-1:0]     r_n2;
    logic [2:0]          r_sgnb;
    logic                r_zb;
    logic                r_vb;
    logic [2:0]          r_dsgn [ELAT];
    logic [ELAT-1:0]     r_dz;
    logic [ELAT-1:0]     r_dv;
    logic [F+1:0]        w_root [3];
    logic [F+2:0]        n_up   [3];
    t_rot                n_rot  [3];
    t_rot                r_rot  [3];
    logic                r_vf;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_mag[k] = RED_BITS'(i_vec[k][RED_W-1] ? -i_vec[k] : i_vec[k]);
            n_sq[k]  = n_mag[k] * n_mag[k];
        end
    end

    for (genvar gk = 0; gk < 3; gk++) begin : g_lane
        tpfb_elem #(.F(F)) u_elem (
            .i_clk  (i_clk),
            .i_en   (i_en),
            .i_v2   (r_v2[gk]),
            .i_n2   (r_n2),
            .o_root (w_root[gk])
        );
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_up[k]  = {1'b0, w_root[k]} + (F+3)'(1);
            n_rot[k] = ROT_BITS'(n_up[k][F+2:1]);
            if (r_dsgn[ELAT-1][k]) begin
                n_rot[k] = -n_rot[k];
            end
            if (r_dz[ELAT-1]) begin
                n_rot[k] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 3; k++) begin
                r_sq[k]   <= n_sq[k];
                r_sgna[k] <= i_vec[k][RED_W-1];
            end
            r_v2   <= r_sq;
            r_n2   <= N2_W'(r_sq[0]) + N2_W'(r_sq[1]) + N2_W'(r_sq[2]);
            r_zb   <= (r_sq[0] | r_sq[1] | r_sq[2]) == '0;
            r_sgnb <= r_sgna;
            r_dsgn[0] <= r_sgnb;
            for (int s = 1; s < ELAT; s++) begin
                r_dsgn[s] <= r_dsgn[s-1];
            end
            r_dz  <= {r_dz[ELAT-2:0], r_zb};
            r_rot <= n_rot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_dv <= '0;
            r_vf <= 1'b0;
        end else if (i_en) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_dv <= {r_dv[ELAT-2:0], r_vb};
            r_vf <= r_dv[ELAT-1];
        end
    end

    assign o_valid = r_vf;
    assign o_rot   = r_rot;

    a_rot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vf |-> (r_rot[0] <= LIM && r_rot[0] >= -LIM && r_rot[1] <= LIM
                  && r_rot[1] >= -LIM && r_rot[2] <= LIM && r_rot[2] >= -LIM))
        else $error("rotation element out of range");

    a_zero_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dv[ELAT-1] && r_dz[ELAT-1] && i_en)
        |=> (r_rot[0] == 0 && r_rot[1] == 0 && r_rot[2] == 0))
        else $error("zero-length column not zeroed");

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the three point frame builder: random and directed
// point triples are pushed through a valid/ready driver, a bit-exact
// integer predictor computes each expected frame, and a monitor compares
// every accepted frame field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import tpfb_pkg::*;

    localparam int FRAC      = 30;
    localparam int LATENCY   = 3 * FRAC + 23;
    localparam int N_RANDOM  = 500;
    localparam int CYC_LIMIT = 400000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_item   in_data = '0;
    logic       in_ready;
    logic       out_valid;
    t_out_item  out_data;
    logic       out_ready = 1'b0;
    logic       in_ready_q = 1'b0;

    t_in_item   pending_reqs[$];
    t_out_item  expected_frames[$];
    int         errors = 0;
    int         cycles = 0;
    bit         stim_done = 1'b0;
    bit         quiet_tail = 1'b0;
    int         drv_gap = 0;
    int         mon_stall = 0;

    three_point_frame_builder #(.ROT_FRAC_BITS(FRAC)) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .i_in_data  (in_data),
        .o_in_ready (in_ready),
        .o_out_valid(out_valid),
        .o_out_data (out_data),
        .i_out_ready(out_ready)
    );

    initial begin
        forever #2 clk = ~clk;
    end

    function automatic longint unsigned abs_mag(longint v);
        return v < 0 ? longint'(-v) : v;
    endfunction

    function automatic void prescale(ref longint v[3]);
        longint unsigned m;
        int s;
        m = 0;
        s = 0;
        for (int i = 0; i < 3; i++) if (abs_mag(v[i]) > m) m = abs_mag(v[i]);
        while (m >= 64'd1 << 30) begin
            m = m >> 1;
            s++;
        end
        for (int i = 0; i < 3; i++)
            v[i] = v[i] < 0 ? -longint'(abs_mag(v[i]) >> s) : longint'(abs_mag(v[i]) >> s);
    endfunction

    function automatic void cross3(longint a[3], longint b[3], ref longint r[3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic logic [31:0] unit_component(longint unsigned v, longint unsigned n2);
        logic [127:0] rhs;
        logic [127:0] lhs;
        longint unsigned lo, hi, mid, t;
        rhs = 128'(v * v) << (2 * FRAC + 2);
        lo = 0;
        hi = 64'd1 << FRAC;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            t = 2 * mid - 1;
            lhs = 128'(t * t) * 128'(n2);
            if (lhs <= rhs) lo = mid;
            else hi = mid - 1;
        end
        return lo[31:0];
    endfunction

    function automatic void unit_column(longint v[3], ref logic [31:0] col[3]);
        longint unsigned n2;
        n2 = 0;
        for (int i = 0; i < 3; i++) n2 += abs_mag(v[i]) * abs_mag(v[i]);
        for (int i = 0; i < 3; i++) begin
            col[i] = 32'd0;
            if (n2 != 0) begin
                col[i] = unit_component(abs_mag(v[i]), n2);
                if (v[i] < 0) col[i] = -col[i];
            end
        end
    endfunction

    function automatic t_out_item predict_frame(t_in_item p);
        longint o[3], x[3], pl[3], z[3], y[3];
        logic [31:0] cx[3], cy[3], cz[3];
        t_out_item r;
        o[0] = p.origin_x;
        o[1] = p.origin_y;
        o[2] = p.origin_z;
        x[0] = longint'(p.axis_pt_x) - o[0];
        x[1] = longint'(p.axis_pt_y) - o[1];
        x[2] = longint'(p.axis_pt_z) - o[2];
        pl[0] = longint'(p.plane_pt_x) - o[0];
        pl[1] = longint'(p.plane_pt_y) - o[1];
        pl[2] = longint'(p.plane_pt_z) - o[2];
        prescale(x);
        prescale(pl);
        cross3(x, pl, z);
        prescale(z);
        cross3(z, x, y);
        prescale(y);
        unit_column(x, cx);
        unit_column(y, cy);
        unit_column(z, cz);
        r.rot_00 = cx[0]; r.rot_10 = cx[1]; r.rot_20 = cx[2];
        r.rot_01 = cy[0]; r.rot_11 = cy[1]; r.rot_21 = cy[2];
        r.rot_02 = cz[0]; r.rot_12 = cz[1]; r.rot_22 = cz[2];
        r.shift_x = p.origin_x;
        r.shift_y = p.origin_y;
        r.shift_z = p.origin_z;
        return r;
    endfunction

    function automatic t_coord rand_coord(int mode);
        case (mode)
            0: return t_coord'($urandom);
            1: return t_coord'(int'($urandom_range(0, 2000)) - 1000);
            2: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
            default: return t_coord'(int'($urandom_range(0, 1 << 16)) - (1 << 15));
        endcase
    endfunction

    function automatic t_in_item make_pts(int ox, int oy, int oz,
                                          int ax, int ay, int az,
                                          int bx, int by, int bz);
        t_in_item p;
        p.origin_x   = t_coord'(ox);
        p.origin_y   = t_coord'(oy);
        p.origin_z   = t_coord'(oz);
        p.axis_pt_x  = t_coord'(ax);
        p.axis_pt_y  = t_coord'(ay);
        p.axis_pt_z  = t_coord'(az);
        p.plane_pt_x = t_coord'(bx);
        p.plane_pt_y = t_coord'(by);
        p.plane_pt_z = t_coord'(bz);
        return p;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h want %h", what, got, want);
        errors++;
    endtask

    initial begin
        t_in_item p;
        int mode;
        int mx, mn;
        mx = 8388607;
        mn = -8388608;
        pending_reqs.push_back(make_pts(0, 0, 0, 64, 0, 0, 0, 64, 0));
        pending_reqs.push_back(make_pts(0, 0, 0, 0, 0, 0, 0, 64, 0));
        pending_reqs.push_back(make_pts(0, 0, 0, 64, 0, 0, 128, 0, 0));
        pending_reqs.push_back(make_pts(0, 0, 0, 0, 0, 0, 0, 0, 0));
        pending_reqs.push_back(make_pts(mn, mn, mn, mx, mx, mx, mx, mn, mx));
        pending_reqs.push_back(make_pts(mx, mx, mx, mn, mn, mn, mn, mx, mn));
        pending_reqs.push_back(make_pts(mn, 0, 0, mx, 0, 0, mn, mx, 0));
        pending_reqs.push_back(make_pts(0, 0, 0, 1, 0, 0, 0, 1, 0));
        pending_reqs.push_back(make_pts(0, 0, 0, 1, 1, 1, 2, 2, 2));
        pending_reqs.push_back(make_pts(5, 5, 5, 4, 5, 5, 5, 5, 4));
        pending_reqs.push_back(make_pts(0, 0, 0, mx, 1, 0, 1, mx, 0));
        pending_reqs.push_back(make_pts(0, 0, 0, mx, mx, mx, mn, mx, mn));
        pending_reqs.push_back(make_pts(-64, -64, -64, -128, -64, -64, -64, -128, -64));
        pending_reqs.push_back(make_pts(0, 0, 0, 0, 0, 64, 0, 64, 0));
        pending_reqs.push_back(make_pts(0, 0, 0, mn, mn, mn, 1, 0, 0));
        pending_reqs.push_back(make_pts(0, 0, 0, 3, -7, 11, -13, 2, 5));
        for (int n = 0; n < N_RANDOM; n++) begin
            mode = $urandom_range(0, 3);
            p.origin_x = rand_coord(mode);   p.origin_y = rand_coord(mode);
            p.origin_z = rand_coord(mode);
            p.axis_pt_x = rand_coord(mode);  p.axis_pt_y = rand_coord(mode);
            p.axis_pt_z = rand_coord(mode);
            p.plane_pt_x = rand_coord(mode); p.plane_pt_y = rand_coord(mode);
            p.plane_pt_z = rand_coord(mode);
            if ($urandom_range(0, 15) == 0) begin
                p.plane_pt_x = t_coord'(int'(p.origin_x)
                                        + 2 * (int'(p.axis_pt_x) - int'(p.origin_x)));
                p.plane_pt_y = t_coord'(int'(p.origin_y)
                                        + 2 * (int'(p.axis_pt_y) - int'(p.origin_y)));
                p.plane_pt_z = t_coord'(int'(p.origin_z)
                                        + 2 * (int'(p.axis_pt_z) - int'(p.origin_z)));
            end
            if ($urandom_range(0, 31) == 0) begin
                p.axis_pt_x = p.origin_x;
                p.axis_pt_y = p.origin_y;
                p.axis_pt_z = p.origin_z;
            end
            pending_reqs.push_back(p);
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // driver
    always @(negedge clk) begin
        if (rst_n) begin
            quiet_tail <= pending_reqs.size() < 60;
            if (!in_valid || in_ready_q) begin
                if (drv_gap > 0) begin
                    drv_gap <= drv_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_reqs.size() > 0) begin
                    in_data <= pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    if (!quiet_tail && $urandom_range(0, 19) == 0)
                        drv_gap <= $urandom_range(1, 15);
                end else begin
                    in_valid <= 1'b0;
                    stim_done <= 1'b1;
                end
            end
            if (mon_stall > 0) begin
                mon_stall <= mon_stall - 1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
                if (!quiet_tail && $urandom_range(0, 19) == 0)
                    mon_stall <= $urandom_range(1, 15);
            end
        end
    end

    // request acceptance and frame check
    always @(posedge clk) begin
        t_out_item want;
        in_ready_q <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
            expected_frames.push_back(predict_frame(in_data));
        if (rst_n && out_valid && out_ready) begin
            if (expected_frames.size() == 0) begin
                report_mismatch("unexpected frame", 0, 0);
            end else begin
                want = expected_frames.pop_front();
                if (out_data.rot_00 !== want.rot_00)
                    report_mismatch("rot_00", out_data.rot_00, want.rot_00);
                if (out_data.rot_01 !== want.rot_01)
                    report_mismatch("rot_01", out_data.rot_01, want.rot_01);
                if (out_data.rot_02 !== want.rot_02)
                    report_mismatch("rot_02", out_data.rot_02, want.rot_02);
                if (out_data.rot_10 !== want.rot_10)
                    report_mismatch("rot_10", out_data.rot_10, want.rot_10);
                if (out_data.rot_11 !== want.rot_11)
                    report_mismatch("rot_11", out_data.rot_11, want.rot_11);
                if (out_data.rot_12 !== want.rot_12)
                    report_mismatch("rot_12", out_data.rot_12, want.rot_12);
                if (out_data.rot_20 !== want.rot_20)
                    report_mismatch("rot_20", out_data.rot_20, want.rot_20);
                if (out_data.rot_21 !== want.rot_21)
                    report_mismatch("rot_21", out_data.rot_21, want.rot_21);
                if (out_data.rot_22 !== want.rot_22)
                    report_mismatch("rot_22", out_data.rot_22, want.rot_22);
                if (out_data.shift_x !== want.shift_x)
                    report_mismatch("shift_x", 32'(out_data.shift_x), 32'(want.shift_x));
                if (out_data.shift_y !== want.shift_y)
                    report_mismatch("shift_y", 32'(out_data.shift_y), 32'(want.shift_y));
                if (out_data.shift_z !== want.shift_z)
                    report_mismatch("shift_z", 32'(out_data.shift_z), 32'(want.shift_z));
            end
        end
    end

    initial begin
        wait (stim_done);
        wait (expected_frames.size() == 0);
        repeat (LATENCY + 20) @(posedge clk);
        if (errors == 0 && expected_frames.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

>>> three_point_frame_builder.f
rtl/tpfb_pkg.sv
rtl/tpfb_reduce.sv
rtl/tpfb_cross.sv
rtl/tpfb_elem.sv
rtl/tpfb_column.sv
rtl/three_point_frame_builder.sv
tb/tb_top.sv
